>>> hw/rtl/dfq_pkg.sv
// dfq_pkg: shared constants, request/status codes, transaction structs and ring
// arithmetic for the duplicate-checking FIFO queue.
// No dependencies; used by dedup_fifo_queue.sv and dfq_checker.sv.
`default_nettype none

package dfq_pkg;

    // Queue geometry and field widths
    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 16;
    localparam int PAY_BITS = 32;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int WORD_W   = KEY_BITS + PAY_BITS;

    // Request codes
    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_SEARCH = 3'd2;
    localparam logic [2:0] REQ_PEEK   = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NONE = 2'd3;

    // Request transaction
    typedef struct packed {
        logic [2:0]          req_type;
        logic [KEY_BITS-1:0] key_id;
        logic [PAY_BITS-1:0] entry_payload;
    } req_t;

    // Response transaction
    typedef struct packed {
        logic [1:0]          status;
        logic [KEY_BITS-1:0] out_id;
        logic [PAY_BITS-1:0] out_payload;
        logic                queue_empty;
        logic [CNT_W-1:0]    occupancy;
    } rsp_t;

    // Ring slot of (base + offset); offset never exceeds DEPTH
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] offset);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W+1-PTR_W){1'b0}}, base} + {1'b0, offset};
        if (sum >= (CNT_W+1)'(DEPTH))
            sum = sum - (CNT_W+1)'(DEPTH);
        return sum[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dfq_ram.sv
// dfq_ram: generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none

module dfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/dedup_fifo_queue.sv
// dedup_fifo_queue: bounded FIFO of key/payload entries that refuses duplicate keys.
// Depends on dfq_pkg and dfq_ram.
//
//  channel   | signals                  | handshake
//  ----------+--------------------------+-------------------------------------
//  request   | start, busy, req (req_t) | taken on clk edge with start && !busy
//  response  | done, rsp (rsp_t)        | one-cycle strobe, always taken
//
// Insert and search walk the queue head to tail through the RAM read port, one
// entry per cycle, and stop early when the key matches. Remove/peek of a held
// entry go through S_READ for one RAM read; clear, unused codes and remove/peek
// on an empty queue answer straight from S_IDLE. The response strobe follows the
// last cycle. Reset empties the queue at once; there is no clearing pass. The
// receiver cannot stall; busy is the only back-pressure.
`default_nettype none

module dedup_fifo_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire dfq_pkg::req_t req,
    output logic               done,
    output dfq_pkg::rsp_t      rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    logic [dfq_pkg::PTR_W-1:0]     head_reg, head_next;
    logic [dfq_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [dfq_pkg::CNT_W-1:0]     idx_reg, idx_next;
    logic                          cmp_vld_reg, cmp_vld_next;
    dfq_pkg::req_t                 op_reg, op_next;
    logic                          done_reg, done_next;
    dfq_pkg::rsp_t                 rsp_reg, rsp_next;

    logic                          ram_we;
    logic [dfq_pkg::PTR_W-1:0]     ram_waddr;
    logic [dfq_pkg::PTR_W-1:0]     ram_raddr;
    logic [dfq_pkg::WORD_W-1:0]    ram_wdata;
    logic [dfq_pkg::WORD_W-1:0]    ram_rdata;
    logic [dfq_pkg::KEY_BITS-1:0]  rd_key;
    logic [dfq_pkg::PAY_BITS-1:0]  rd_pay;

    logic                          fire;
    logic [1:0]                    r_status;
    logic [dfq_pkg::KEY_BITS-1:0]  r_id;
    logic [dfq_pkg::PAY_BITS-1:0]  r_pay;

    // Entry storage: key in the upper bits, payload in the lower
    assign ram_raddr = dfq_pkg::ring_add(head_reg, idx_reg);
    assign ram_waddr = dfq_pkg::ring_add(head_reg, count_reg);
    assign ram_wdata = {op_reg.key_id, op_reg.entry_payload};
    assign rd_key    = ram_rdata[dfq_pkg::WORD_W-1:dfq_pkg::PAY_BITS];
    assign rd_pay    = ram_rdata[dfq_pkg::PAY_BITS-1:0];

    dfq_ram #(
        .WIDTH(dfq_pkg::WORD_W),
        .DEPTH(dfq_pkg::DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Sequencer and response formation
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        cmp_vld_next = cmp_vld_reg;
        op_next      = op_reg;
        rsp_next     = rsp_reg;
        ram_we       = 1'b0;
        fire         = 1'b0;
        r_status     = dfq_pkg::ST_NONE;
        r_id         = '0;
        r_pay        = '0;

        case (state_reg)
            S_IDLE:
            begin
                idx_next     = '0;
                cmp_vld_next = 1'b0;
                if (start)
                begin
                    op_next = req;
                    case (req.req_type)
                        dfq_pkg::REQ_INSERT, dfq_pkg::REQ_SEARCH:
                        begin
                            state_next = S_SCAN;
                        end
                        dfq_pkg::REQ_REMOVE, dfq_pkg::REQ_PEEK:
                        begin
                            // head slot is being read this cycle (idx is zero)
                            if (count_reg == '0)
                                fire = 1'b1;
                            else
                                state_next = S_READ;
                        end
                        dfq_pkg::REQ_CLEAR:
                        begin
                            head_next  = '0;
                            count_next = '0;
                            r_status   = dfq_pkg::ST_OK;
                            fire       = 1'b1;
                        end
                        default:
                        begin
                            fire = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // compare the entry read last cycle, issue the next read
                if (cmp_vld_reg && (rd_key == op_reg.key_id))
                begin
                    fire       = 1'b1;
                    state_next = S_IDLE;
                    if (op_reg.req_type == dfq_pkg::REQ_INSERT)
                    begin
                        r_status = dfq_pkg::ST_DUP;
                    end
                    else
                    begin
                        r_status = dfq_pkg::ST_OK;
                        r_id     = rd_key;
                        r_pay    = rd_pay;
                    end
                end
                else if (idx_reg == count_reg)
                begin
                    fire       = 1'b1;
                    state_next = S_IDLE;
                    if (op_reg.req_type == dfq_pkg::REQ_INSERT)
                    begin
                        if (count_reg == dfq_pkg::CNT_W'(dfq_pkg::DEPTH))
                        begin
                            r_status = dfq_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                            r_status   = dfq_pkg::ST_OK;
                        end
                    end
                end
                else
                begin
                    idx_next     = idx_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end
            end

            S_READ:
            begin
                fire       = 1'b1;
                state_next = S_IDLE;
                r_status   = dfq_pkg::ST_OK;
                r_id       = rd_key;
                r_pay      = rd_pay;
                if (op_reg.req_type == dfq_pkg::REQ_REMOVE)
                begin
                    head_next  = dfq_pkg::ring_add(head_reg, dfq_pkg::CNT_W'(1));
                    count_next = count_reg - 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_next == S_IDLE)
        begin
            idx_next     = '0;
            cmp_vld_next = 1'b0;
        end

        done_next = fire;
        if (fire)
        begin
            rsp_next.status      = r_status;
            rsp_next.out_id      = r_id;
            rsp_next.out_payload = r_pay;
            rsp_next.queue_empty = (count_next == '0);
            rsp_next.occupancy   = count_next;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            cmp_vld_reg <= cmp_vld_next;
            done_reg    <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

>>> hw/rtl/dfq_checker.sv
// dfq_port_props: port-level assertions for dedup_fifo_queue, attached by bind.
// Depends on dfq_pkg and dedup_fifo_queue.
`default_nettype none

module dfq_port_props (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire dfq_pkg::req_t req,
    input wire logic          done,
    input wire dfq_pkg::rsp_t rsp
);

    // A response never appears while a transaction is still being worked
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response strobe while busy");

    // Busy only rises right after an accepted request
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    // Occupancy bounded and consistent with the empty flag
    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((rsp.occupancy <= dfq_pkg::CNT_W'(dfq_pkg::DEPTH))
                  && (rsp.queue_empty == (rsp.occupancy == '0))))
        else $error("occupancy out of range or empty flag mismatch");

    // Not-found (ST_NONE) responses return zeroed fields
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status == dfq_pkg::ST_NONE))
            |-> ((rsp.out_id == '0) && (rsp.out_payload == '0)))
        else $error("not-found response carries data");

    // Clear always succeeds and empties the queue
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.req_type == dfq_pkg::REQ_CLEAR))
            |=> (done && (rsp.status == dfq_pkg::ST_OK) && rsp.queue_empty))
        else $error("clear did not empty the queue");

endmodule

bind dedup_fifo_queue dfq_port_props u_dfq_port_props (.*);

`default_nettype wire
